[rtl/core/led_blink_pulse_pattern_driver_assert.svh]
// Assertion macros shared by the LED driver RTL.
`ifndef LED_BLINK_PULSE_PATTERN_DRIVER_ASSERT_SVH
`define LED_BLINK_PULSE_PATTERN_DRIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LBPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LBPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpd: next-cycle check failed");

`endif

[rtl/core/lbpd_pkg.sv]
// Types, constants and duty table functions for the LED blink and pulse driver.
package lbpd_pkg;

    localparam int PIN_COUNT  = 32;
    localparam int PWM_PERIOD = 1000;

    localparam int PIN_W      = 5;
    localparam int LEVEL_W    = 32;
    localparam int CMD_W      = 3;
    localparam int DUR_W      = 18;
    localparam int LFSR_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = $clog2(PWM_PERIOD);
    localparam int DUTY_W     = IDX_W;
    localparam int BIG_W      = 256;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [DUR_W-1:0]  ON_MIN_RESET  = 18'd50000;
    localparam logic [DUR_W-1:0]  ON_MAX_RESET  = 18'd200000;
    localparam logic [DUR_W-1:0]  OFF_MIN_RESET = 18'd25000;
    localparam logic [DUR_W-1:0]  OFF_MAX_RESET = 18'd75000;
    localparam logic [LFSR_W-1:0] SEED_RESET    = 32'd1;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_BLINK = 3'd1,
        CMD_PULSE = 3'd2,
        CMD_OFF   = 3'd3,
        CMD_ON    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_PULSE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_BLINK_ON  = 3'd0,
        PH_BLINK_OFF = 3'd1,
        PH_UP_HIGH   = 3'd2,
        PH_UP_LOW    = 3'd3,
        PH_DOWN_HIGH = 3'd4,
        PH_DOWN_LOW  = 3'd5,
        PH_TAIL      = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        CFG_ON_MIN  = 3'd0,
        CFG_ON_MAX  = 3'd1,
        CFG_OFF_MIN = 3'd2,
        CFG_OFF_MAX = 3'd3,
        CFG_SEED    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        logic [CMD_W-1:0] cmd;
        logic [PIN_W-1:0] pin;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] levels;
        logic [LEVEL_W-1:0] enables;
        t_mode              mode;
        logic [PIN_W-1:0]   pin;
        logic               waiting;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef logic [DUTY_W-1:0] t_duty_table [PWM_PERIOD];

    // Largest d with d^10 * PWM_PERIOD^11 <= i^21, in exact wide integers.
    function automatic int unsigned duty_exact(int unsigned i);
        logic [BIG_W-1:0] target;
        logic [BIG_W-1:0] trial;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int unsigned      k;
        lo = 0;
        hi = PWM_PERIOD - 1;
        if (i == 0 || i >= PWM_PERIOD) begin
            return 0;
        end
        target = BIG_W'(1);
        for (k = 0; k < 21; k++) begin
            target = target * BIG_W'(i);
        end
        while (lo < hi) begin
            mid   = (lo + hi + 1) / 2;
            trial = BIG_W'(1);
            for (k = 0; k < 10; k++) begin
                trial = trial * BIG_W'(mid);
            end
            for (k = 0; k < 11; k++) begin
                trial = trial * BIG_W'(PWM_PERIOD);
            end
            if (trial <= target) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic t_duty_table duty_table();
        t_duty_table tab;
        int unsigned i;
        for (i = 0; i < PWM_PERIOD; i++) begin
            tab[i] = DUTY_W'(duty_exact(i));
        end
        return tab;
    endfunction

    // The duty curve is nondecreasing, so zero duties form a prefix.
    function automatic int unsigned first_on();
        int unsigned i;
        for (i = 0; i < PWM_PERIOD; i++) begin
            if (duty_exact(i) != 0) begin
                return i;
            end
        end
        return PWM_PERIOD - 1;
    endfunction

    localparam logic [IDX_W-1:0]  IDX_FIRST_ON  = IDX_W'(first_on());
    localparam logic [IDX_W-1:0]  IDX_LAST      = IDX_W'(PWM_PERIOD - 1);
    localparam logic [DUTY_W-1:0] DUTY_FIRST_ON = DUTY_W'(duty_exact(first_on()));

endpackage

[rtl/core/lbpd_if.sv]
// Handshake channels of the LED driver: item input, result output, register writes.
interface lbpd_in_if;
    import lbpd_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [CMD_W-1:0] command_code;
    logic [PIN_W-1:0] pin_number;

    modport source (output valid, output operation, output command_code,
                    output pin_number, input ready);
    modport sink   (input valid, input operation, input command_code,
                    input pin_number, output ready);
endinterface

interface lbpd_out_if;
    import lbpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pin_levels;
    logic [LEVEL_W-1:0] output_enables;
    logic [1:0]         current_mode;
    logic [PIN_W-1:0]   selected_pin;
    logic               command_waiting;

    modport source (output valid, output pin_levels, output output_enables,
                    output current_mode, output selected_pin, output command_waiting,
                    input ready);
    modport sink   (input valid, input pin_levels, input output_enables,
                    input current_mode, input selected_pin, input command_waiting,
                    output ready);
endinterface

interface lbpd_cfg_if;
    import lbpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/lbpd_duty_rom.sv]
// Breathing duty table with a registered read port.
module lbpd_duty_rom (
    input  logic                        i_clk,
    input  logic [lbpd_pkg::IDX_W-1:0]  i_addr,
    output logic [lbpd_pkg::DUTY_W-1:0] o_duty
);
    import lbpd_pkg::*;

    localparam t_duty_table DUTY_ROM = duty_table();

    logic [DUTY_W-1:0] r_duty;

    always_ff @(posedge i_clk) begin
        if ({1'b0, i_addr} < (IDX_W + 1)'(PWM_PERIOD)) begin
            r_duty <= DUTY_ROM[i_addr];
        end else begin
            r_duty <= '0;
        end
    end

    assign o_duty = r_duty;

endmodule

[rtl/core/lbpd_engine.sv]
// Pin state, blink and breathing sequencer, random draws and register file.
`include "led_blink_pulse_pattern_driver_assert.svh"

module lbpd_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbpd_pkg::t_cfg_wr i_cfg,
    input  logic              i_fire,
    input  lbpd_pkg::t_item   i_item,
    output lbpd_pkg::t_result o_next
);
    import lbpd_pkg::*;

    // State registers and their next values.
    t_mode              r_mode,       n_mode;
    logic [PIN_W-1:0]   r_active,     n_active;
    logic [LEVEL_W-1:0] r_levels,     n_levels;
    logic [LEVEL_W-1:0] r_enables,    n_enables;
    logic               r_wait_valid, n_wait_valid;
    t_cmd               r_wait_cmd,   n_wait_cmd;
    logic [PIN_W-1:0]   r_wait_pin,   n_wait_pin;
    t_phase             r_phase,      n_phase;
    logic [IDX_W-1:0]   r_index,      n_index;
    logic [DUTY_W-1:0]  r_duty,       n_duty;
    logic [DUR_W-1:0]   r_dur,        n_dur;
    logic [LFSR_W-1:0]  r_lfsr,       n_lfsr;

    logic [DUR_W-1:0]   r_on_min;
    logic [DUR_W-1:0]   r_on_max;
    logic [DUR_W-1:0]   r_off_min;
    logic [DUR_W-1:0]   r_off_max;

    logic [IDX_W-1:0]        w_rom_addr;
    logic [DUTY_W-1:0]       w_rom_duty;
    logic                    w_sel_off;
    logic [LFSR_W-1:0]       w_lfsr_adv;
    logic [DUR_W-1:0]        w_lo;
    logic [DUR_W-1:0]        w_hi;
    logic [DUR_W-1:0]        w_span;
    logic [DUR_W+LFSR_W-1:0] w_prod;
    logic [DUR_W-1:0]        w_draw;
    logic [DUR_W-1:0]        w_dec;
    logic                    w_cmd_ok;
    logic                    w_go;
    t_cmd                    w_go_cmd;
    logic [PIN_W-1:0]        w_go_pin;
    logic                    w_start;
    logic                    w_set;
    logic                    w_clr;
    logic                    w_draw_used;
    logic                    w_ramp_phase;
    logic                    w_idx_ok;
    logic                    w_idle_tick;

    // The table is read one step ahead: the next index while ramping up and
    // the previous one while ramping down, so a step boundary finds it ready.
    always_comb begin
        if (r_phase == PH_UP_HIGH || r_phase == PH_UP_LOW) begin
            w_rom_addr = (r_index == IDX_LAST) ? r_index : r_index + 1'b1;
        end else begin
            w_rom_addr = r_index - 1'b1;
        end
    end

    lbpd_duty_rom u_duty_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_duty (w_rom_duty)
    );

    // One draw per transaction at most: off bounds only when the high half
    // of a blink ends, on bounds for every blink cycle start.
    always_comb begin
        w_sel_off  = (r_mode == MODE_BLINK) && (r_phase == PH_BLINK_ON);
        w_lfsr_adv = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
        w_lo       = w_sel_off ? r_off_min : r_on_min;
        w_hi       = w_sel_off ? r_off_max : r_on_max;
        w_span     = (w_hi > w_lo) ? w_hi - w_lo : '0;
        w_prod     = (DUR_W + LFSR_W)'(w_span) * (DUR_W + LFSR_W)'(w_lfsr_adv);
        w_draw     = w_lo + w_prod[DUR_W+LFSR_W-1:LFSR_W];
    end

    assign w_cmd_ok = (i_item.cmd <= CMD_ON) && (int'(i_item.pin) < PIN_COUNT);
    assign w_dec    = (r_dur != '0) ? r_dur - 1'b1 : '0;

    always_comb begin
        n_mode       = r_mode;
        n_active     = r_active;
        n_levels     = r_levels;
        n_enables    = r_enables;
        n_wait_valid = r_wait_valid;
        n_wait_cmd   = r_wait_cmd;
        n_wait_pin   = r_wait_pin;
        n_phase      = r_phase;
        n_index      = r_index;
        n_duty       = r_duty;
        n_dur        = r_dur;
        n_lfsr       = r_lfsr;
        w_go         = 1'b0;
        w_go_cmd     = r_wait_cmd;
        w_go_pin     = r_wait_pin;
        w_start      = 1'b0;
        w_set        = 1'b0;
        w_clr        = 1'b0;
        w_draw_used  = 1'b0;

        if (i_fire) begin
            if (i_item.op == OP_CMD) begin
                if (w_cmd_ok) begin
                    if (r_mode >= MODE_BLINK) begin
                        // A newer command replaces the one already waiting.
                        n_wait_valid = 1'b1;
                        n_wait_cmd   = t_cmd'(i_item.cmd);
                        n_wait_pin   = i_item.pin;
                    end else begin
                        w_go     = 1'b1;
                        w_go_cmd = t_cmd'(i_item.cmd);
                        w_go_pin = i_item.pin;
                    end
                end
            end else if (r_mode >= MODE_BLINK) begin
                n_dur = w_dec;
                if (w_dec == '0) begin
                    unique case (r_phase) inside
                        PH_BLINK_ON: begin
                            n_dur       = w_draw;
                            w_draw_used = 1'b1;
                            w_clr       = 1'b1;
                            n_phase     = PH_BLINK_OFF;
                        end
                        PH_UP_HIGH, PH_DOWN_HIGH: begin
                            n_dur   = DUR_W'(PWM_PERIOD) - DUR_W'(r_duty);
                            w_clr   = 1'b1;
                            n_phase = (r_phase == PH_UP_HIGH) ? PH_UP_LOW : PH_DOWN_LOW;
                        end
                        PH_UP_LOW: begin
                            // The top step turns the ramp around at the same index.
                            if (r_index == IDX_LAST) begin
                                n_phase = PH_DOWN_HIGH;
                            end else begin
                                n_index = r_index + 1'b1;
                                n_phase = PH_UP_HIGH;
                            end
                            n_duty = w_rom_duty;
                            n_dur  = DUR_W'(w_rom_duty);
                            w_set  = 1'b1;
                        end
                        PH_DOWN_LOW: begin
                            // Indices below the first nonzero duty are skipped.
                            if (r_index <= IDX_FIRST_ON) begin
                                n_dur   = DUR_W'(PWM_PERIOD);
                                n_phase = PH_TAIL;
                            end else begin
                                n_index = r_index - 1'b1;
                                n_duty  = w_rom_duty;
                                n_dur   = DUR_W'(w_rom_duty);
                                w_set   = 1'b1;
                                n_phase = PH_DOWN_HIGH;
                            end
                        end
                        default: begin
                            if (r_wait_valid) begin
                                n_wait_valid = 1'b0;
                                w_go         = 1'b1;
                            end else begin
                                w_start = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end

        if (w_go) begin
            n_active = w_go_pin;
            unique case (w_go_cmd)
                CMD_INIT: begin
                    n_enables[w_go_pin] = 1'b1;
                    w_start             = 1'b1;
                end
                CMD_BLINK: begin
                    n_mode  = MODE_BLINK;
                    w_start = 1'b1;
                end
                CMD_PULSE: begin
                    n_mode  = MODE_PULSE;
                    w_start = 1'b1;
                end
                CMD_OFF: begin
                    n_mode = MODE_IDLE;
                    w_clr  = 1'b1;
                end
                default: begin
                    n_mode = MODE_ON;
                    w_set  = 1'b1;
                end
            endcase
        end

        if (w_start) begin
            case (n_mode)
                MODE_BLINK: begin
                    n_dur       = w_draw;
                    w_draw_used = 1'b1;
                    w_set       = 1'b1;
                    n_phase     = PH_BLINK_ON;
                end
                MODE_PULSE: begin
                    n_index = IDX_FIRST_ON;
                    n_duty  = DUTY_FIRST_ON;
                    n_dur   = DUR_W'(DUTY_FIRST_ON);
                    w_set   = 1'b1;
                    n_phase = PH_UP_HIGH;
                end
                default: begin
                end
            endcase
        end

        if (w_set) begin
            n_levels[n_active] = 1'b1;
        end else if (w_clr) begin
            n_levels[n_active] = 1'b0;
        end

        if (w_draw_used) begin
            n_lfsr = w_lfsr_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_active     <= '0;
            r_levels     <= '0;
            r_enables    <= '0;
            r_wait_valid <= 1'b0;
            r_wait_cmd   <= CMD_INIT;
            r_wait_pin   <= '0;
            r_phase      <= PH_BLINK_ON;
            r_index      <= '0;
            r_duty       <= '0;
            r_dur        <= '0;
            r_lfsr       <= SEED_RESET;
            r_on_min     <= ON_MIN_RESET;
            r_on_max     <= ON_MAX_RESET;
            r_off_min    <= OFF_MIN_RESET;
            r_off_max    <= OFF_MAX_RESET;
        end else begin
            if (i_fire) begin
                r_mode       <= n_mode;
                r_active     <= n_active;
                r_levels     <= n_levels;
                r_enables    <= n_enables;
                r_wait_valid <= n_wait_valid;
                r_wait_cmd   <= n_wait_cmd;
                r_wait_pin   <= n_wait_pin;
                r_phase      <= n_phase;
                r_index      <= n_index;
                r_duty       <= n_duty;
                r_dur        <= n_dur;
            end
            // A seed write reloads the generator ahead of any draw in the same cycle.
            if (i_cfg.we && t_cfg_idx'(i_cfg.idx) == CFG_SEED) begin
                r_lfsr <= i_cfg.data;
            end else if (i_fire) begin
                r_lfsr <= n_lfsr;
            end
            if (i_cfg.we) begin
                unique case (t_cfg_idx'(i_cfg.idx))
                    CFG_ON_MIN:  r_on_min  <= DUR_W'(i_cfg.data);
                    CFG_ON_MAX:  r_on_max  <= DUR_W'(i_cfg.data);
                    CFG_OFF_MIN: r_off_min <= DUR_W'(i_cfg.data);
                    CFG_OFF_MAX: r_off_max <= DUR_W'(i_cfg.data);
                    CFG_SEED: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_next.levels  = n_levels;
    assign o_next.enables = n_enables;
    assign o_next.mode    = n_mode;
    assign o_next.pin     = n_active;
    assign o_next.waiting = n_wait_valid;

    assign w_ramp_phase = (r_phase == PH_UP_HIGH) || (r_phase == PH_UP_LOW) ||
                          (r_phase == PH_DOWN_HIGH) || (r_phase == PH_DOWN_LOW);
    assign w_idx_ok     = (r_index >= IDX_FIRST_ON) && (r_index <= IDX_LAST);
    assign w_idle_tick  = i_fire && (i_item.op == OP_TICK) && (r_mode < MODE_BLINK);

    `LBPD_ASSERT_IMP(a_wait_only_running, i_clk, i_rst_n, r_wait_valid, r_mode >= MODE_BLINK)
    `LBPD_ASSERT_IMP(a_ramp_idx, i_clk, i_rst_n, r_mode == MODE_PULSE && w_ramp_phase, w_idx_ok)
    `LBPD_ASSERT_NXT(a_idle_tick, i_clk, i_rst_n, w_idle_tick, $stable(r_levels) && $stable(r_dur))

endmodule

[rtl/core/led_blink_pulse_pattern_driver.sv]
// Top level of the LED blink and breathing pulse driver.
// Flow: an accepted transaction waits in the input register, is processed once the
// result slot is free or being emptied, and its result is then offered from the result register.
// Throughput: one item per clock while the output is not stalled; the input register and result register decouple
// the two channels, so an item is taken while a finished result waits.
// Reset: i_rst_n is synchronous and active low; it clears all pin state, loads the
// default blink bounds and seeds the random generator; no clearing pass follows.
`include "led_blink_pulse_pattern_driver_assert.svh"

module led_blink_pulse_pattern_driver (
    input logic         i_clk,
    input logic         i_rst_n,
    lbpd_in_if.sink     i_item,
    lbpd_out_if.source  o_result,
    lbpd_cfg_if.sink    i_cfg
);
    import lbpd_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    w_fire;
    t_result w_next;
    t_cfg_wr w_cfg;

    // The item in the input register is processed once the result slot is free
    // or being emptied in the same cycle.
    assign w_fire       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_fire;
    assign i_cfg.ready  = 1'b1;

    assign w_cfg.we   = i_cfg.valid;
    assign w_cfg.idx  = i_cfg.index;
    assign w_cfg.data = i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.op  <= t_op'(i_item.operation);
            r_in.cmd <= i_item.command_code;
            r_in.pin <= i_item.pin_number;
        end
        if (w_fire) begin
            r_out <= w_next;
        end
    end

    lbpd_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .o_next  (w_next)
    );

    assign o_result.valid           = r_out_valid;
    assign o_result.pin_levels      = r_out.levels;
    assign o_result.output_enables  = r_out.enables;
    assign o_result.current_mode    = r_out.mode;
    assign o_result.selected_pin    = r_out.pin;
    assign o_result.command_waiting = r_out.waiting;

    `LBPD_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_result.ready, !i_item.ready)
    `LBPD_ASSERT_NXT(a_fire_fills_output, i_clk, i_rst_n, w_fire, r_out_valid)

endmodule
